/* sv/mtxmul_pkg.sv */
`default_nettype none

package mtxmul_pkg;

    // Fixed field widths of the streaming item.
    localparam int ELEM_W    = 32;
    localparam int ROW_W     = 2;
    localparam int FIELDS    = 4;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ELEM_LSB  = ROW_W;
    localparam int TDATA_W   = ((ROW_W + FIELDS * ELEM_W + 7) / 8) * 8;

    // Defaults for the top-level parameters.
    localparam int DIM_DEFAULT       = 4;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic        [ROW_W-1:0]  row_idx_t;

    typedef enum logic {
        MODE_LOAD     = 1'b0,
        MODE_MULTIPLY = 1'b1
    } mode_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

endpackage

`default_nettype wire

/* sv/mtxmul_store.sv */
`default_nettype none

// Right-hand matrix held in flip-flops; every entry feeds its own multiplier.
module mtxmul_store #(
    parameter int LANES = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire mtxmul_pkg::row_idx_t    wr_row,
    input  wire mtxmul_pkg::elem_t       wr_data [mtxmul_pkg::FIELDS],
    output mtxmul_pkg::elem_t            mat     [LANES][LANES]
);

    mtxmul_pkg::elem_t mat_reg [LANES][LANES];

    // A row number with no matching store row is dropped.
    always_ff @(posedge aclk) begin
        for (int r = 0; r < LANES; r++) begin
            if (wr_en && (wr_row == mtxmul_pkg::ROW_W'(r))) begin
                for (int c = 0; c < LANES; c++) begin
                    mat_reg[r][c] <= wr_data[c];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
                mat[r][c] = mat_reg[r][c];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/mtxmul_mul.sv */
`default_nettype none

// One signed 32 x 32 multiplier per matrix entry, each with its own register.
module mtxmul_mul #(
    parameter int LANES = 4
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire mtxmul_pkg::elem_t   left [LANES],
    input  wire mtxmul_pkg::elem_t   mat  [LANES][LANES],
    output mtxmul_pkg::prod_t        prod [LANES][LANES]
);

    mtxmul_pkg::prod_t prod_next [LANES][LANES];
    mtxmul_pkg::prod_t prod_reg  [LANES][LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int c = 0; c < LANES; c++) begin
                prod_next[k][c] = left[k] * mat[k][c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int c = 0; c < LANES; c++) begin
                prod[k][c] = prod_reg[k][c];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/mtxmul_sum.sv */
`default_nettype none

// Column sums of the products, floor shift by the fraction bits, saturation.
module mtxmul_sum #(
    parameter int LANES     = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire mtxmul_pkg::prod_t   prod [LANES][LANES],
    output mtxmul_pkg::elem_t        col  [mtxmul_pkg::FIELDS]
);

    localparam int SUM_W = mtxmul_pkg::PROD_W + $clog2(LANES);
    localparam int TOP_W = SUM_W - mtxmul_pkg::ELEM_W + 1;

    logic signed [SUM_W-1:0] sum      [LANES];
    logic signed [SUM_W-1:0] shifted  [LANES];
    logic        [TOP_W-1:0] top_bits [LANES];
    mtxmul_pkg::elem_t       col_next [mtxmul_pkg::FIELDS];
    mtxmul_pkg::elem_t       col_reg  [mtxmul_pkg::FIELDS];

    always_comb begin
        for (int f = 0; f < mtxmul_pkg::FIELDS; f++) begin
            col_next[f] = '0;
        end
        for (int c = 0; c < LANES; c++) begin
            sum[c] = '0;
            for (int k = 0; k < LANES; k++) begin
                sum[c] = sum[c] + SUM_W'(prod[k][c]);
            end
            shifted[c]  = sum[c] >>> FRAC_BITS;
            top_bits[c] = shifted[c][SUM_W-1:mtxmul_pkg::ELEM_W-1];
            if ((&top_bits[c]) || !(|top_bits[c])) begin
                col_next[c] = shifted[c][mtxmul_pkg::ELEM_W-1:0];
            end else if (shifted[c][SUM_W-1]) begin
                col_next[c] = mtxmul_pkg::ELEM_MIN;
            end else begin
                col_next[c] = mtxmul_pkg::ELEM_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg <= col_next;
        end
    end

    assign col = col_reg;

endmodule

`default_nettype wire

/* sv/matrix4x4_row_multiply_core.sv */
`default_nettype none

// Row-at-a-time matrix multiplier in signed fixed point with FRAC_BITS fraction
// bits (Q16.16 by default). A transfer with s_tuser low loads one row of the
// stored right-hand matrix and gives no result; a transfer with s_tuser high
// carries one row of the left matrix and, once that row has passed the input,
// multiplier and output registers, offers the matching product row on the
// master side. Each product is the exact sum of the full 64-bit products of the
// row with one stored column, shifted right arithmetically (rounding towards
// minus infinity) and saturated to 32 bits. One transfer is taken every cycle for
// as long as the master side keeps up: the pipeline is an input register, a bank
// of sixteen registered multipliers and the summing and saturating output
// register, and s_tready follows m_tready through that three-stage enable chain.
// A loaded row takes effect for every multiply transfer that follows it, even in
// the very next cycle. Stored rows have no reset and must be loaded before they
// are used. When DIM is below four only the first DIM columns take part, loads
// to rows at or beyond DIM are dropped and the unused product fields read as zero.
module matrix4x4_row_multiply_core #(
    parameter int DIM       = mtxmul_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mtxmul_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata from bit 0: row_index[1:0], element_0, element_1, element_2,
    // element_3 (32 bits each), zero padding.
    input  wire logic [mtxmul_pkg::TDATA_W-1:0]    s_tdata,
    // tuser: mode (0 = load a right-matrix row, 1 = multiply).
    input  wire logic [0:0]                        s_tuser,
    // Result channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata from bit 0: result_row[1:0], product_0, product_1, product_2,
    // product_3 (32 bits each), zero padding.
    output logic [mtxmul_pkg::TDATA_W-1:0]         m_tdata
);

    localparam int LANES = (DIM < mtxmul_pkg::FIELDS) ? DIM : mtxmul_pkg::FIELDS;

    // Pipeline occupancy and stage enables.
    logic in_valid_reg,  in_valid_next;
    logic mul_valid_reg, mul_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_adv, mul_adv, out_adv;
    logic s_accept, is_multiply;

    mtxmul_pkg::elem_t    s_elem [mtxmul_pkg::FIELDS];
    mtxmul_pkg::elem_t    in_left_reg [LANES];
    mtxmul_pkg::row_idx_t in_row_reg, mul_row_reg, out_row_reg;
    mtxmul_pkg::elem_t    mat  [LANES][LANES];
    mtxmul_pkg::prod_t    prod [LANES][LANES];
    mtxmul_pkg::elem_t    col  [mtxmul_pkg::FIELDS];

    // A stage moves on when it is empty or the stage after it moves on.
    assign out_adv  = !out_valid_reg || m_tready;
    assign mul_adv  = !mul_valid_reg || out_adv;
    assign in_adv   = !in_valid_reg  || mul_adv;
    assign s_tready = in_adv;
    assign s_accept = s_tvalid && s_tready;
    assign is_multiply = (s_tuser[0] == mtxmul_pkg::MODE_MULTIPLY);

    always_comb begin
        for (int f = 0; f < mtxmul_pkg::FIELDS; f++) begin
            s_elem[f] = s_tdata[mtxmul_pkg::ELEM_LSB + f * mtxmul_pkg::ELEM_W +:
                                mtxmul_pkg::ELEM_W];
        end
    end

    always_comb begin
        in_valid_next  = in_adv  ? (s_accept && is_multiply) : in_valid_reg;
        mul_valid_next = mul_adv ? in_valid_reg  : mul_valid_reg;
        out_valid_next = out_adv ? mul_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags above qualify them.
    always_ff @(posedge aclk) begin
        if (in_adv) begin
            in_row_reg <= s_tdata[mtxmul_pkg::ROW_W-1:0];
            for (int k = 0; k < LANES; k++) begin
                in_left_reg[k] <= s_elem[k];
            end
        end
        if (mul_adv) begin
            mul_row_reg <= in_row_reg;
        end
        if (out_adv) begin
            out_row_reg <= mul_row_reg;
        end
    end

    // The store is written as a load transfer is taken. A multiply row sitting
    // in the input register reads the store in the same cycle, so it sees every
    // load that came before it and none that came after.
    mtxmul_store #(
        .LANES (LANES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept && !is_multiply),
        .wr_row  (s_tdata[mtxmul_pkg::ROW_W-1:0]),
        .wr_data (s_elem),
        .mat     (mat)
    );

    mtxmul_mul #(
        .LANES (LANES)
    ) u_mul (
        .aclk (aclk),
        .en   (mul_adv),
        .left (in_left_reg),
        .mat  (mat),
        .prod (prod)
    );

    mtxmul_sum #(
        .LANES     (LANES),
        .FRAC_BITS (FRAC_BITS)
    ) u_sum (
        .aclk (aclk),
        .en   (out_adv),
        .prod (prod),
        .col  (col)
    );

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[mtxmul_pkg::ROW_W-1:0] = out_row_reg;
        for (int f = 0; f < mtxmul_pkg::FIELDS; f++) begin
            m_tdata[mtxmul_pkg::ELEM_LSB + f * mtxmul_pkg::ELEM_W +:
                    mtxmul_pkg::ELEM_W] = col[f];
        end
    end

    // The pipeline is empty straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !(in_valid_reg || mul_valid_reg || out_valid_reg))
        else $error("pipeline not empty after reset");

    // A load transfer never occupies a pipeline stage.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !is_multiply) |=> !in_valid_reg)
        else $error("load transfer entered the pipeline");

    // A multiply transfer always lands in the input register.
    a_multiply_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_multiply) |=> in_valid_reg)
        else $error("multiply transfer lost at the input");

    // With every stage full and the output stalled, nothing more is taken.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && mul_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("transfer taken while the pipeline is stalled");

    // A product row in the multiplier stage reaches the output when it moves on.
    a_mul_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_valid_reg && out_adv) |=> out_valid_reg)
        else $error("product row dropped between stages");

endmodule

`default_nettype wire

/* tb/sv/tb_matrix4x4_row_multiply_core.sv */
module tb_matrix4x4_row_multiply_core;

    typedef mtxmul_pkg::elem_t    elem_t;
    typedef mtxmul_pkg::row_idx_t row_idx_t;
    typedef mtxmul_pkg::mode_t    mode_t;

    localparam int    ELEM_W        = mtxmul_pkg::ELEM_W;
    localparam int    ROW_W         = mtxmul_pkg::ROW_W;
    localparam int    FIELDS        = mtxmul_pkg::FIELDS;
    localparam int    TDATA_W       = mtxmul_pkg::TDATA_W;
    localparam elem_t ELEM_MAX      = mtxmul_pkg::ELEM_MAX;
    localparam elem_t ELEM_MIN      = mtxmul_pkg::ELEM_MIN;
    localparam mode_t MODE_LOAD     = mtxmul_pkg::MODE_LOAD;
    localparam mode_t MODE_MULTIPLY = mtxmul_pkg::MODE_MULTIPLY;

    localparam int DIM          = mtxmul_pkg::DIM_DEFAULT;
    localparam int FRAC_BITS    = mtxmul_pkg::FRAC_BITS_DEFAULT;
    localparam int PAD_W        = TDATA_W - ROW_W - FIELDS * ELEM_W;
    localparam int ACC_W        = 2 * ELEM_W + 4;
    localparam int RANDOM_ROWS  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 120;

    localparam elem_t Q_ONE   = 32'sh0001_0000;
    localparam elem_t Q_LSB   = 32'sd1;
    localparam elem_t Q_MINUS = -32'sd1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ELEM_MAX;
    localparam logic signed [ACC_W-1:0] SAT_LO = ELEM_MIN;

    // Same layout for both channels: row index in the low bits, then the four words.
    typedef struct packed {
        logic [PAD_W-1:0]         pad;
        elem_t [FIELDS-1:0]       elem;
        row_idx_t                 row;
    } row_word_t;

    typedef struct {
        mode_t     md;
        row_word_t item;
        bit        has_exp;
        row_word_t want;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;

    elem_t     right_store [FIELDS][FIELDS];
    row_word_t expected_rows [$];
    stim_row_t stimulus_rows [$];
    int        accepted_items = 0;
    int        mismatches = 0;
    int        burst_left = 0;

    matrix4x4_row_multiply_core #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    initial begin
        #800000;
        $display("tb_matrix4x4_row_multiply_core failed");
        $finish;
    end

    function automatic elem_t [FIELDS-1:0] quad(input elem_t e0, input elem_t e1,
                                                input elem_t e2, input elem_t e3);
        elem_t [FIELDS-1:0] q;
        q[0] = e0;
        q[1] = e1;
        q[2] = e2;
        q[3] = e3;
        return q;
    endfunction

    // Exact sum of the full products, floored by the fraction shift, then clamped.
    function automatic row_word_t multiply_row(input row_word_t lhs);
        row_word_t                res;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  a;
        logic signed [ACC_W-1:0]  b;
        res = '0;
        res.row = lhs.row;
        for (int c = 0; c < FIELDS; c++) begin
            acc = '0;
            for (int k = 0; k < FIELDS; k++) begin
                a = $signed(lhs.elem[k]);
                b = $signed(right_store[k][c]);
                acc = acc + a * b;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > SAT_HI) begin
                res.elem[c] = ELEM_MAX;
            end else if (acc < SAT_LO) begin
                res.elem[c] = ELEM_MIN;
            end else begin
                res.elem[c] = acc[ELEM_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic elem_t random_element();
        case ($urandom_range(9)) inside
            0: return ELEM_MAX;
            1: return ELEM_MIN;
            2: return '0;
            [3:5]: return elem_t'($urandom_range(32'h0020_0000)) - elem_t'(32'h0010_0000);
            default: return elem_t'($urandom);
        endcase
    endfunction

    task automatic add_row(input mode_t md, input row_idx_t row, input elem_t [FIELDS-1:0] e,
                           input bit has_exp = 1'b0, input elem_t [FIELDS-1:0] x = '0);
        stim_row_t entry;
        entry.md = md;
        entry.item = '0;
        entry.item.row = row;
        entry.item.elem = e;
        entry.has_exp = has_exp;
        entry.want = '0;
        entry.want.row = row;
        entry.want.elem = x;
        stimulus_rows.push_back(entry);
    endtask

    // The sender runs in bursts with idle gaps between them; some bursts are long, and rows go back to back within one.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            if ($urandom_range(3) == 0) begin
                burst_left = $urandom_range(40, 80);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
        end
        burst_left--;
    endtask

    task automatic transfer_row(input mode_t md, input row_word_t item,
                                input bit has_exp, input row_word_t want);
        pace_sender();
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
        accepted_items++;
        if (md == MODE_LOAD) begin
            for (int c = 0; c < FIELDS; c++) right_store[item.row][c] = item.elem[c];
        end else if (has_exp) begin
            expected_rows.push_back(want);
        end else begin
            expected_rows.push_back(multiply_row(item));
        end
    endtask

    initial begin : stimulus
        mode_t     md;
        row_word_t item;

        // An identity matrix passes every left row through unchanged, extremes included.
        add_row(MODE_LOAD, 0, quad(Q_ONE, 0, 0, 0));
        add_row(MODE_LOAD, 1, quad(0, Q_ONE, 0, 0));
        add_row(MODE_LOAD, 2, quad(0, 0, Q_ONE, 0));
        add_row(MODE_LOAD, 3, quad(0, 0, 0, Q_ONE));
        add_row(MODE_MULTIPLY, 0, quad(ELEM_MAX, ELEM_MIN, 0, Q_MINUS), 1'b1,
                quad(ELEM_MAX, ELEM_MIN, 0, Q_MINUS));
        add_row(MODE_MULTIPLY, 3, quad(Q_LSB, -Q_ONE, 32'sh7FFF_0000, 32'sh8000_0001), 1'b1,
                quad(Q_LSB, -Q_ONE, 32'sh7FFF_0000, 32'sh8000_0001));
        add_row(MODE_MULTIPLY, 2, quad(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0003_8000,
                                       -32'sh0000_4000));
        // A matrix of largest values drives every column of an extreme left row into saturation.
        add_row(MODE_LOAD, 0, quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        add_row(MODE_LOAD, 1, quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        add_row(MODE_LOAD, 2, quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        add_row(MODE_LOAD, 3, quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        add_row(MODE_MULTIPLY, 2, quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX), 1'b1,
                quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        add_row(MODE_MULTIPLY, 1, quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN), 1'b1,
                quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        add_row(MODE_MULTIPLY, 3, quad(0, 0, 0, 0), 1'b1, quad(0, 0, 0, 0));
        // Most negative values: the sum of four products reaches two to the sixty-fourth.
        add_row(MODE_LOAD, 0, quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        add_row(MODE_LOAD, 1, quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        add_row(MODE_LOAD, 2, quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        add_row(MODE_LOAD, 3, quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        add_row(MODE_MULTIPLY, 0, quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN), 1'b1,
                quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        add_row(MODE_MULTIPLY, 1, quad(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX), 1'b1,
                quad(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        // One raw LSB in row 0: a tiny negative product must round down to minus one.
        add_row(MODE_LOAD, 0, quad(Q_LSB, Q_LSB, Q_LSB, Q_LSB));
        add_row(MODE_LOAD, 1, quad(0, 0, 0, 0));
        add_row(MODE_LOAD, 2, quad(0, 0, 0, 0));
        add_row(MODE_LOAD, 3, quad(0, 0, 0, 0));
        add_row(MODE_MULTIPLY, 1, quad(Q_MINUS, 0, 0, 0), 1'b1,
                quad(Q_MINUS, Q_MINUS, Q_MINUS, Q_MINUS));
        add_row(MODE_MULTIPLY, 2, quad(Q_LSB, 0, 0, 0), 1'b1, quad(0, 0, 0, 0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stimulus_rows[i]) begin
            transfer_row(stimulus_rows[i].md, stimulus_rows[i].item,
                         stimulus_rows[i].has_exp, stimulus_rows[i].want);
        end

        // Every stored row is written by now, so any mix of loads and multiplies is legal.
        for (int n = 0; n < RANDOM_ROWS; n++) begin
            if ($urandom_range(3) == 0) begin
                md = MODE_LOAD;
            end else begin
                md = MODE_MULTIPLY;
            end
            item = '0;
            item.row = row_idx_t'($urandom_range(3));
            for (int c = 0; c < FIELDS; c++) item.elem[c] = random_element();
            transfer_row(md, item, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_matrix4x4_row_multiply_core passed");
        end else begin
            $display("tb_matrix4x4_row_multiply_core failed");
        end
        $finish;
    end

    // The receiver changes its stall rate phase by phase, and holds off once for a long
    // stretch so that the pipeline fills and back-pressures the sender.
    initial begin : result_sink
        int  hold_left;
        int  phase_left;
        int  stall_pct;
        bit  held;
        hold_left = 0;
        phase_left = 0;
        stall_pct = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && accepted_items >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(20, 120);
                    case ($urandom_range(4)) inside
                        [0:1]: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 55;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        row_word_t got;
        row_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_rows.size() == 0) begin
                $display("%0t: result for row %0d with no product outstanding", $time, got.row);
                mismatches++;
            end else begin
                want = expected_rows.pop_front();
                if (got.row !== want.row) begin
                    $display("%0t: result_row expected %0d, got %0d", $time, want.row, got.row);
                    mismatches++;
                end
                for (int c = 0; c < FIELDS; c++) begin
                    if (got.elem[c] !== want.elem[c]) begin
                        $display("%0t: product_%0d of row %0d expected %0d, got %0d",
                                 $time, c, want.row, $signed(want.elem[c]),
                                 $signed(got.elem[c]));
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

/* files.f */
sv/mtxmul_pkg.sv
sv/mtxmul_store.sv
sv/mtxmul_mul.sv
sv/mtxmul_sum.sv
sv/matrix4x4_row_multiply_core.sv
tb/sv/tb_matrix4x4_row_multiply_core.sv
